@@ design/ustw_pkg.sv @@
// ----------------------------------------------------------------------------
// ustw_pkg
// Shared constants, register codes and controller/datapath bundles for the
// block-to-row write descriptor generator.
// ----------------------------------------------------------------------------
package ustw_pkg;

  localparam int TILE_DIM        = 32;
  localparam int TILE_LOG2       = 5;
  localparam int BYTES_PER_ELEM  = 2;
  localparam int ELEM_LOG2       = 1;
  localparam int MAX_BLOCK_TILES = 64;
  localparam int MAX_BPR         = 4096;
  localparam int MAX_TRPB        = 2048;

  // payload widths
  localparam int BASE_W  = 21;
  localparam int SRC_W   = 22;
  localparam int STICK_W = 32;
  localparam int OFF_W   = 17;
  localparam int BYTES_W = 13;

  // configuration port
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 32;

  // register widths
  localparam int BPR_W   = 13;
  localparam int TRPB_W  = 12;
  localparam int RPB_W   = 16;
  localparam int RW_W    = 16;
  localparam int TILES_W = 7;
  localparam int BLK_W   = 24;

  // internal widths
  localparam int COL_W   = 12;
  localparam int TRIB_W  = 11;
  localparam int NROW_W  = 6;
  localparam int ROW_W   = 5;
  localparam int NCOL_W  = 12;
  localparam int PITCH_W = 13;
  localparam int COL0_W  = COL_W + TILES_W + TILE_LOG2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BLOCKS_PER_ROW      = 4'd0,
    REG_TILE_ROWS_PER_BATCH = 4'd1,
    REG_ROWS_PER_BATCH      = 4'd2,
    REG_ROW_WIDTH           = 4'd3,
    REG_FULL_BLOCK_TILES    = 4'd4,
    REG_LAST_BLOCK_TILES    = 4'd5,
    REG_FIRST_BLOCK         = 4'd6,
    REG_BLOCK_TOTAL         = 4'd7
  } reg_idx_e;

  typedef struct packed {
    logic in_take;
    logic div_start;
    logic div_sel;
    logic div1_load;
    logic div2_load;
    logic calc1;
    logic calc2;
    logic row_step;
    logic block_end;
  } cmd_t;

  typedef struct packed {
    logic job_done;
    logic busy;
    logic div_done;
    logic nrows_zero;
    logic last_row;
  } status_t;

endpackage

@@ design/ustw_in_if.sv @@
// ----------------------------------------------------------------------------
// ustw_in_if
// Input channel: one ready block page per item.
// ----------------------------------------------------------------------------
interface ustw_in_if;
  import ustw_pkg::*;

  logic              valid;
  logic              ready;
  logic [BASE_W-1:0] page_base;

  modport source (output valid, output page_base, input ready);
  modport sink   (input valid, input page_base, output ready);
endinterface

@@ design/ustw_out_if.sv @@
// ----------------------------------------------------------------------------
// ustw_out_if
// Output channel: one row write descriptor per item.
// ----------------------------------------------------------------------------
interface ustw_out_if;
  import ustw_pkg::*;

  logic               valid;
  logic               ready;
  logic [SRC_W-1:0]   src_address;
  logic [STICK_W-1:0] stick_id;
  logic [OFF_W-1:0]   dst_offset;
  logic [BYTES_W-1:0] byte_count;
  logic               block_last;
  logic               all_done;

  modport source (output valid, output src_address, output stick_id, output dst_offset,
                  output byte_count, output block_last, output all_done, input ready);
  modport sink   (input valid, input src_address, input stick_id, input dst_offset,
                  input byte_count, input block_last, input all_done, output ready);
endinterface

@@ design/ustw_cfg_if.sv @@
// ----------------------------------------------------------------------------
// ustw_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface ustw_cfg_if;
  import ustw_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ design/ustw_div.sv @@
// ----------------------------------------------------------------------------
// ustw_div
// Restoring divider, one quotient bit per cycle. Used twice at job start to
// split the first block index into column, tile row and batch.
// ----------------------------------------------------------------------------
module ustw_div (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [ustw_pkg::BLK_W-1:0] dividend_i,
  input  logic [ustw_pkg::BPR_W-1:0] divisor_i,
  output logic                     done_o,
  output logic [ustw_pkg::BLK_W-1:0] quot_o,
  output logic [ustw_pkg::COL_W-1:0] rem_o
);
  import ustw_pkg::*;

  localparam int CNT_W = $clog2(BLK_W);

  logic [BLK_W-1:0] quot_q;
  logic [COL_W-1:0] rem_q;
  logic [BPR_W-1:0] dsr_q;
  logic [CNT_W-1:0] cnt_q;
  logic             run_q;
  logic             done_q;
  logic [BPR_W-1:0] trial;
  logic [BPR_W-1:0] diff;
  logic             ge;

  assign trial = {rem_q, quot_q[BLK_W-1]};
  assign ge    = trial >= dsr_q;
  assign diff  = trial - dsr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        cnt_q <= cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(BLK_W - 1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quot_q <= dividend_i;
      rem_q  <= '0;
      dsr_q  <= divisor_i;
    end else if (run_q) begin
      quot_q <= {quot_q[BLK_W-2:0], ge};
      rem_q  <= ge ? diff[COL_W-1:0] : trial[COL_W-1:0];
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;
  assign rem_o  = rem_q;

endmodule

@@ design/ustw_dp.sv @@
// ----------------------------------------------------------------------------
// ustw_dp
// Datapath: configuration registers, block position counters, per-block
// geometry and the row descriptor registers.
// ----------------------------------------------------------------------------
module ustw_dp (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [ustw_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [ustw_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic [ustw_pkg::BASE_W-1:0]     page_base_i,
  input  ustw_pkg::cmd_t                  cmd_i,
  output ustw_pkg::status_t               status_o,
  output logic [ustw_pkg::SRC_W-1:0]      src_address_o,
  output logic [ustw_pkg::STICK_W-1:0]    stick_id_o,
  output logic [ustw_pkg::OFF_W-1:0]      dst_offset_o,
  output logic [ustw_pkg::BYTES_W-1:0]    byte_count_o,
  output logic                            block_last_o,
  output logic                            all_done_o
);
  import ustw_pkg::*;

  // configuration
  logic [BPR_W-1:0]   bpr_q;
  logic [TRPB_W-1:0]  trpb_q;
  logic [RPB_W-1:0]   rpb_q;
  logic [RW_W-1:0]    rw_q;
  logic [TILES_W-1:0] fbt_q;
  logic [TILES_W-1:0] lbt_q;
  logic [BLK_W-1:0]   first_q;
  logic [BLK_W-1:0]   total_q;
  logic               cfg_hit;

  // position state
  logic [COL_W-1:0]  col_q;
  logic [TRIB_W-1:0] trib_q;
  logic [BLK_W-1:0]  batch_q;
  logic [BLK_W-1:0]  done_cnt_q;
  logic              busy_q;

  // clamped geometry
  logic [BPR_W-1:0]   bpr_c;
  logic [TRPB_W-1:0]  trpb_c;
  logic [TILES_W-1:0] fbt_c;
  logic [TILES_W-1:0] lbt_c;
  logic               lir;
  logic [TRPB_W-1:0]  trib_inc;

  // divider
  logic [BLK_W-1:0] div_dividend;
  logic [BPR_W-1:0] div_divisor;
  logic             div_done;
  logic [BLK_W-1:0] div_quot;
  logic [COL_W-1:0] div_rem;

  // block geometry, first stage
  logic [BASE_W-1:0]          base_q;
  logic [COL_W+TILES_W-1:0]   col_prod;
  logic [STICK_W-1:0]         bs_prod;
  logic [COL0_W-1:0]          col0_q;
  logic [STICK_W-1:0]         bs_q;
  logic                       lir_q;
  logic [TILES_W-1:0]         bw_q;
  logic [RPB_W-1:0]           row0_q;

  // block geometry, second stage
  logic               row_ge;
  logic [RPB_W-1:0]   rdiff;
  logic [NROW_W-1:0]  nrows_c;
  logic               col_ge;
  logic [RW_W-1:0]    cdiff;
  logic [NCOL_W-1:0]  cap;
  logic [NCOL_W-1:0]  ncols_c;
  logic [OFF_W-1:0]   off_c;
  logic [PITCH_W-1:0] pitch_c;
  logic               final_c;

  // row registers
  logic [SRC_W-1:0]   src_q;
  logic [STICK_W-1:0] stick_q;
  logic [OFF_W-1:0]   off_q;
  logic [BYTES_W-1:0] bytes_q;
  logic [PITCH_W-1:0] pitch_q;
  logic [NROW_W-1:0]  nrows_q;
  logic [ROW_W-1:0]   row_q;
  logic               final_q;
  logic               last_row;

  assign bpr_c  = (bpr_q == '0) ? BPR_W'(1) :
                  (bpr_q > BPR_W'(MAX_BPR)) ? BPR_W'(MAX_BPR) : bpr_q;
  assign trpb_c = (trpb_q == '0) ? TRPB_W'(1) :
                  (trpb_q > TRPB_W'(MAX_TRPB)) ? TRPB_W'(MAX_TRPB) : trpb_q;
  assign fbt_c  = (fbt_q == '0) ? TILES_W'(1) :
                  (fbt_q > TILES_W'(MAX_BLOCK_TILES)) ? TILES_W'(MAX_BLOCK_TILES) : fbt_q;
  assign lbt_c  = (lbt_q == '0) ? TILES_W'(1) :
                  (lbt_q > TILES_W'(MAX_BLOCK_TILES)) ? TILES_W'(MAX_BLOCK_TILES) : lbt_q;

  assign lir      = {1'b0, col_q} >= (bpr_c - BPR_W'(1));
  assign trib_inc = {1'b0, trib_q} + TRPB_W'(1);

  // register decode
  always_comb begin
    cfg_hit = 1'b0;
    if (cfg_we_i) begin
      unique case (cfg_index_i) inside
        REG_BLOCKS_PER_ROW, REG_TILE_ROWS_PER_BATCH, REG_ROWS_PER_BATCH, REG_ROW_WIDTH,
        REG_FULL_BLOCK_TILES, REG_LAST_BLOCK_TILES, REG_FIRST_BLOCK,
        REG_BLOCK_TOTAL: cfg_hit = 1'b1;
        default:         cfg_hit = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bpr_q      <= BPR_W'(1);
      trpb_q     <= TRPB_W'(1);
      rpb_q      <= RPB_W'(32);
      rw_q       <= RW_W'(32);
      fbt_q      <= TILES_W'(1);
      lbt_q      <= TILES_W'(1);
      first_q    <= '0;
      total_q    <= '0;
      col_q      <= '0;
      trib_q     <= '0;
      batch_q    <= '0;
      done_cnt_q <= '0;
      busy_q     <= 1'b0;
    end else if (cfg_hit) begin
      busy_q     <= 1'b0;
      done_cnt_q <= '0;
      unique case (cfg_index_i)
        REG_BLOCKS_PER_ROW:      bpr_q   <= cfg_data_i[BPR_W-1:0];
        REG_TILE_ROWS_PER_BATCH: trpb_q  <= cfg_data_i[TRPB_W-1:0];
        REG_ROWS_PER_BATCH:      rpb_q   <= cfg_data_i[RPB_W-1:0];
        REG_ROW_WIDTH:           rw_q    <= cfg_data_i[RW_W-1:0];
        REG_FULL_BLOCK_TILES:    fbt_q   <= cfg_data_i[TILES_W-1:0];
        REG_LAST_BLOCK_TILES:    lbt_q   <= cfg_data_i[TILES_W-1:0];
        REG_FIRST_BLOCK:         first_q <= cfg_data_i[BLK_W-1:0];
        REG_BLOCK_TOTAL:         total_q <= cfg_data_i[BLK_W-1:0];
        default: ;
      endcase
    end else begin
      if (cmd_i.div1_load) begin
        col_q <= div_rem;
      end
      if (cmd_i.div2_load) begin
        batch_q <= div_quot;
        trib_q  <= div_rem[TRIB_W-1:0];
        busy_q  <= 1'b1;
      end
      if (cmd_i.block_end) begin
        done_cnt_q <= done_cnt_q + BLK_W'(1);
        if (lir_q) begin
          col_q <= '0;
          if (trib_inc >= trpb_c) begin
            trib_q  <= '0;
            batch_q <= batch_q + BLK_W'(1);
          end else begin
            trib_q <= trib_inc[TRIB_W-1:0];
          end
        end else begin
          col_q <= col_q + COL_W'(1);
        end
      end
    end
  end

  // start position: first_block / bpr, then tile row / trpb
  assign div_dividend = cmd_i.div_sel ? div_quot : first_q;
  assign div_divisor  = cmd_i.div_sel ? BPR_W'(trpb_c) : bpr_c;

  ustw_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  assign col_prod = (COL_W+TILES_W)'(col_q) * (COL_W+TILES_W)'(fbt_c);
  assign bs_prod  = STICK_W'(batch_q) * STICK_W'(rpb_q);

  // row clamp
  assign row_ge  = row0_q >= rpb_q;
  assign rdiff   = rpb_q - row0_q;
  assign nrows_c = row_ge ? '0 :
                   (rdiff > RPB_W'(TILE_DIM)) ? NROW_W'(TILE_DIM) : rdiff[NROW_W-1:0];

  // column clamp
  assign col_ge  = col0_q >= COL0_W'(rw_q);
  assign cdiff   = rw_q - col0_q[RW_W-1:0];
  assign cap     = {bw_q, {TILE_LOG2{1'b0}}};
  assign ncols_c = col_ge ? '0 : (cdiff > RW_W'(cap)) ? cap : cdiff[NCOL_W-1:0];
  assign off_c   = col_ge ? '0 : {col0_q[RW_W-1:0], {ELEM_LOG2{1'b0}}};
  assign pitch_c = {bw_q, {(TILE_LOG2 + ELEM_LOG2){1'b0}}};
  assign final_c = ((BLK_W+1)'(done_cnt_q) + (BLK_W+1)'(1)) == (BLK_W+1)'(total_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.in_take) begin
      base_q <= page_base_i;
    end
    if (cmd_i.calc1) begin
      col0_q <= {col_prod, {TILE_LOG2{1'b0}}};
      bs_q   <= bs_prod;
      lir_q  <= lir;
      bw_q   <= lir ? lbt_c : fbt_c;
      row0_q <= {trib_q, {TILE_LOG2{1'b0}}};
    end
    if (cmd_i.calc2) begin
      src_q   <= SRC_W'(base_q);
      stick_q <= bs_q + STICK_W'(row0_q);
      off_q   <= off_c;
      bytes_q <= {ncols_c, {ELEM_LOG2{1'b0}}};
      pitch_q <= pitch_c;
      nrows_q <= nrows_c;
      row_q   <= '0;
      final_q <= final_c;
    end else if (cmd_i.row_step) begin
      src_q   <= src_q + SRC_W'(pitch_q);
      stick_q <= stick_q + STICK_W'(1);
      row_q   <= row_q + ROW_W'(1);
    end
  end

  assign last_row = (NROW_W'(row_q) + NROW_W'(1)) == nrows_q;

  assign status_o.job_done   = done_cnt_q >= total_q;
  assign status_o.busy       = busy_q;
  assign status_o.div_done   = div_done;
  assign status_o.nrows_zero = nrows_c == '0;
  assign status_o.last_row   = last_row;

  assign src_address_o = src_q;
  assign stick_id_o    = stick_q;
  assign dst_offset_o  = off_q;
  assign byte_count_o  = bytes_q;
  assign block_last_o  = last_row;
  assign all_done_o    = last_row & final_q;

endmodule

@@ design/ustw_ctrl.sv @@
// ----------------------------------------------------------------------------
// ustw_ctrl
// Controller: accepts a block page, sequences the start-of-job divisions,
// the two geometry steps and the row emission.
// ----------------------------------------------------------------------------
module ustw_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  ustw_pkg::status_t status_i,
  output ustw_pkg::cmd_t    cmd_o
);
  import ustw_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV1,
    ST_DIV2,
    ST_CALC1,
    ST_CALC2,
    ST_EMIT
  } state_e;

  state_e state_q;
  logic   in_ready_q;
  logic   out_valid_q;
  logic   in_acc;
  logic   out_acc;

  assign in_acc  = in_valid_i && in_ready_q;
  assign out_acc = out_valid_q && out_ready_i;

  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc && !status_i.job_done) begin
          cmd_o.in_take   = 1'b1;
          cmd_o.div_start = !status_i.busy;
        end
      end
      ST_DIV1: begin
        if (status_i.div_done) begin
          cmd_o.div1_load = 1'b1;
          cmd_o.div_start = 1'b1;
          cmd_o.div_sel   = 1'b1;
        end
      end
      ST_DIV2: begin
        cmd_o.div_sel   = 1'b1;
        cmd_o.div2_load = status_i.div_done;
      end
      ST_CALC1: cmd_o.calc1 = 1'b1;
      ST_CALC2: begin
        cmd_o.calc2     = 1'b1;
        cmd_o.block_end = status_i.nrows_zero;
      end
      ST_EMIT: begin
        if (out_acc) begin
          cmd_o.block_end = status_i.last_row;
          cmd_o.row_step  = !status_i.last_row;
        end
      end
      default: cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      in_ready_q  <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (in_acc && !status_i.job_done) begin
            in_ready_q <= 1'b0;
            state_q    <= status_i.busy ? ST_CALC1 : ST_DIV1;
          end
        end
        ST_DIV1: begin
          if (status_i.div_done) begin
            state_q <= ST_DIV2;
          end
        end
        ST_DIV2: begin
          if (status_i.div_done) begin
            state_q <= ST_CALC1;
          end
        end
        ST_CALC1: state_q <= ST_CALC2;
        ST_CALC2: begin
          if (status_i.nrows_zero) begin
            in_ready_q <= 1'b1;
            state_q    <= ST_IDLE;
          end else begin
            out_valid_q <= 1'b1;
            state_q     <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (out_acc && status_i.last_row) begin
            out_valid_q <= 1'b0;
            in_ready_q  <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign in_ready_o  = in_ready_q;
  assign out_valid_o = out_valid_q;

endmodule

@@ design/untilize_stick_write_address_gen_core.sv @@
// ----------------------------------------------------------------------------
// untilize_stick_write_address_gen_core
// Turns each ready untilized block page into one write descriptor per row.
// Per page, the CALC1 and CALC2 states register the block geometry before the
// first row goes out; the first page of a job first runs the two start divisions.
// Throughput: one page at a time, one row per cycle while the output is ready;
// the serial start divider sets the job start cost.
// Reset: idle, ready for a page, job counters cleared, registers at defaults.
// ----------------------------------------------------------------------------
module untilize_stick_write_address_gen_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  ustw_cfg_if.sink   cfg_if,
  ustw_in_if.sink    in_if,
  ustw_out_if.source out_if
);
  import ustw_pkg::*;

  cmd_t    cmd;
  status_t status;
  logic    cfg_we;

  assign cfg_if.ready = 1'b1;
  assign cfg_we       = cfg_if.valid && cfg_if.ready;

  ustw_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_if.valid),
    .in_ready_o  (in_if.ready),
    .out_valid_o (out_if.valid),
    .out_ready_i (out_if.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  ustw_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_index_i   (cfg_if.index),
    .cfg_data_i    (cfg_if.data),
    .page_base_i   (in_if.page_base),
    .cmd_i         (cmd),
    .status_o      (status),
    .src_address_o (out_if.src_address),
    .stick_id_o    (out_if.stick_id),
    .dst_offset_o  (out_if.dst_offset),
    .byte_count_o  (out_if.byte_count),
    .block_last_o  (out_if.block_last),
    .all_done_o    (out_if.all_done)
  );

  // no new page while rows are pending
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid |-> !in_if.ready)
    else $error("page accepted while rows pending");

  // job end only on a block end
  a_done_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && out_if.all_done |-> out_if.block_last)
    else $error("all_done without block_last");

  // last row taken ends the block
  a_block_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && out_if.ready && out_if.block_last |=> !out_if.valid && in_if.ready)
    else $error("rows continue after block end");

  // rows only go out after a page came in
  a_rows_after_page: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_if.valid) |-> !in_if.ready)
    else $error("row without page");

endmodule
